// ===== hdl/dapq_pkg.sv =====
`default_nettype none
package dapq_pkg;

    // queue geometry
    localparam int NUM_ACTIONS = 16;
    localparam int MAX_FIRE    = 16;
    localparam int CNT_W       = $clog2(MAX_FIRE + 1);

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int ID_W    = 4;
    localparam int TYPE_W  = 2;
    localparam int PRIO_W  = 8;
    localparam int KIND_W  = 3;
    localparam int LIMIT_W = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

    // request codes
    typedef enum logic [OP_W-1:0] {
        OP_SCHEDULE   = 2'd0,
        OP_FIRE       = 2'd1,
        OP_DESCHEDULE = 2'd2
    } t_op;

    // result codes
    typedef enum logic [KIND_W-1:0] {
        KIND_SCHEDULED  = 3'd0,
        KIND_QUEUED     = 3'd1,
        KIND_FIRED      = 3'd2,
        KIND_FIRE_DONE  = 3'd3,
        KIND_EMPTY      = 3'd4,
        KIND_DESCHEDULE = 3'd5
    } t_kind;

    // one queue slot
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [TYPE_W-1:0] typ;
    } t_entry;

    // what every cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_POP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_entry   ins;
    } t_cell_cmd;

endpackage
`default_nettype wire

// ===== hdl/dapq_in_if.sv =====
`default_nettype none
interface dapq_in_if import dapq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   action_id;
    logic [TYPE_W-1:0] action_type;
    logic [PRIO_W-1:0] priority_req;
    logic [PRIO_W-1:0] current_priority;

    modport source (
        output valid, op, action_id, action_type, priority_req, current_priority,
        input  ready
    );
    modport sink (
        input  valid, op, action_id, action_type, priority_req, current_priority,
        output ready
    );
endinterface
`default_nettype wire

// ===== hdl/dapq_out_if.sv =====
`default_nettype none
interface dapq_out_if import dapq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   out_action;
    logic [TYPE_W-1:0] out_type;
    logic [PRIO_W-1:0] out_priority;
    logic              reschedule_hint;
    logic              last;

    modport source (
        output valid, kind, out_action, out_type, out_priority, reschedule_hint, last,
        input  ready
    );
    modport sink (
        input  valid, kind, out_action, out_type, out_priority, reschedule_hint, last,
        output ready
    );
endinterface
`default_nettype wire

// ===== hdl/dapq_cell.sv =====
`default_nettype none
module dapq_cell import dapq_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cell_cmd  i_cmd,
    input  t_entry     i_left,
    input  wire        i_left_le,
    input  t_entry     i_right,
    input  wire        i_rm,
    output t_entry     o_entry,
    output logic       o_le,
    output logic       o_rm
);

    t_entry r_e;
    t_entry n_e;
    logic   w_match;

    // local compares against the request
    assign w_match = r_e.valid && (r_e.id == i_cmd.ins.id);
    assign o_le    = r_e.valid && (r_e.prio <= i_cmd.ins.prio);
    assign o_rm    = i_rm || w_match;
    assign o_entry = r_e;

    // slot update: keep, take new entry, or shift from a neighbor
    always_comb begin
        n_e = r_e;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (!o_le) begin
                    n_e = i_left_le ? i_cmd.ins : i_left;
                end
            end
            CELL_REMOVE: begin
                if (o_rm) begin
                    n_e = i_right;
                end
            end
            CELL_POP: begin
                n_e = i_right;
            end
            default: begin
                n_e = r_e;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e <= '0;
        end else begin
            r_e <= n_e;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/deferred_action_priority_queue_top.sv =====
// Deferred-action priority queue.
// i_in carries requests (schedule, fire, deschedule); o_out carries results,
// each with a last flag on the final result of its request. Both channels
// transfer at a clock edge where valid and ready are high. i_cfg_we with
// i_cfg_wdata writes the fire limit (0 acts as 1, values above 16 saturate).
// The queue is a row of 16 slot cells kept in priority order; every cell
// compares locally and shifts from its left or right neighbor to insert, remove
// and pop entries, with no search over the row.
// Schedule and deschedule: one result, or none for a deschedule of an absent
// action, registered the cycle after the request transfer.
// Fire: starts the sequencer, then one result per cycle while output is free,
// each fired entry popped, up to the limit or a done result; an empty queue gets an empty result.
// A stalled receiver holds the output register and freezes the sequencer;
// no request is taken while a result cannot be written.
// Synchronous reset empties the queue and sets the fire limit to 8; the block
// is ready in the first cycle after reset.
`default_nettype none
module deferred_action_priority_queue_top import dapq_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [LIMIT_W-1:0]  i_cfg_wdata,
    dapq_in_if.sink            i_in,
    dapq_out_if.source         o_out
);

    typedef enum logic {
        S_IDLE,
        S_FIRE
    } t_state;

    t_state             r_state;
    logic [LIMIT_W-1:0] r_limit;
    logic [PRIO_W-1:0]  r_cur;
    logic [CNT_W-1:0]   r_fired;

    logic               r_ovalid;
    t_kind              r_okind;
    logic [ID_W-1:0]    r_oact;
    logic [TYPE_W-1:0]  r_otype;
    logic [PRIO_W-1:0]  r_oprio;
    logic               r_ohint;
    logic               r_olast;

    t_entry             w_entry [NUM_ACTIONS];
    logic               w_le    [NUM_ACTIONS];
    logic               w_rm    [NUM_ACTIONS];
    t_cell_cmd          w_cmd;
    t_entry             w_hit;
    logic               w_found;
    logic               w_out_free;
    logic               w_accept;
    logic               w_id_ok;
    logic [CNT_W-1:0]   w_lim;
    logic [CNT_W-1:0]   w_fired_inc;
    logic               w_eligible;

    // row of slot cells
    for (genvar g = 0; g < NUM_ACTIONS; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_le;
        logic   w_rm_in;
        if (g == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_le = 1'b1;
            assign w_rm_in   = 1'b0;
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_left_le = w_le[g-1];
            assign w_rm_in   = w_rm[g-1];
        end
        if (g == NUM_ACTIONS - 1) begin : g_end
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end
        dapq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_left    (w_left),
            .i_left_le (w_left_le),
            .i_right   (w_right),
            .i_rm      (w_rm_in),
            .o_entry   (w_entry[g]),
            .o_le      (w_le[g]),
            .o_rm      (w_rm[g])
        );
    end

    // slot holding the requested action, if any
    always_comb begin
        w_hit   = '0;
        w_found = 1'b0;
        for (int i = 0; i < NUM_ACTIONS; i++) begin
            if (w_entry[i].valid && (w_entry[i].id == i_in.action_id)) begin
                w_hit   = w_hit | w_entry[i];
                w_found = 1'b1;
            end
        end
    end

    // effective fire limit
    always_comb begin
        if (r_limit == '0) begin
            w_lim = CNT_W'(1);
        end else if (int'(r_limit) > MAX_FIRE) begin
            w_lim = CNT_W'(MAX_FIRE);
        end else begin
            w_lim = CNT_W'(r_limit);
        end
    end

    assign w_out_free  = !r_ovalid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_id_ok     = int'(i_in.action_id) < NUM_ACTIONS;
    assign w_fired_inc = r_fired + CNT_W'(1);
    assign w_eligible  = w_entry[0].valid && (r_cur >= w_entry[0].prio);

    // command broadcast to the cells
    always_comb begin
        w_cmd.op        = CELL_HOLD;
        w_cmd.ins.valid = 1'b1;
        w_cmd.ins.id    = i_in.action_id;
        w_cmd.ins.prio  = i_in.priority_req;
        w_cmd.ins.typ   = i_in.action_type;
        if (w_accept && w_id_ok && !w_found && (i_in.op == OP_SCHEDULE)) begin
            w_cmd.op = CELL_INSERT;
        end else if (w_accept && w_id_ok && w_found && (i_in.op == OP_DESCHEDULE)) begin
            w_cmd.op = CELL_REMOVE;
        end else if ((r_state == S_FIRE) && w_out_free && w_eligible) begin
            w_cmd.op = CELL_POP;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_fired  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_olast <= 1'b1;
                        case (i_in.op)
                            OP_SCHEDULE: begin
                                r_ovalid <= w_id_ok;
                                if (w_id_ok) begin
                                    r_oact   <= i_in.action_id;
                                    if (w_found) begin
                                        r_okind <= KIND_QUEUED;
                                        r_otype <= w_hit.typ;
                                        r_oprio <= w_hit.prio;
                                        r_ohint <= 1'b0;
                                    end else begin
                                        r_okind <= KIND_SCHEDULED;
                                        r_otype <= i_in.action_type;
                                        r_oprio <= i_in.priority_req;
                                        r_ohint <= (i_in.priority_req <= i_in.current_priority);
                                    end
                                end
                            end
                            OP_FIRE: begin
                                r_ovalid <= !w_entry[0].valid;
                                if (!w_entry[0].valid) begin
                                    r_okind  <= KIND_EMPTY;
                                    r_oact   <= '0;
                                    r_otype  <= '0;
                                    r_oprio  <= '0;
                                    r_ohint  <= 1'b0;
                                end else begin
                                    r_state <= S_FIRE;
                                    r_cur   <= i_in.current_priority;
                                    r_fired <= '0;
                                end
                            end
                            OP_DESCHEDULE: begin
                                r_ovalid <= w_id_ok && w_found;
                                if (w_id_ok && w_found) begin
                                    r_okind  <= KIND_DESCHEDULE;
                                    r_oact   <= i_in.action_id;
                                    r_otype  <= w_hit.typ;
                                    r_oprio  <= w_hit.prio;
                                    r_ohint  <= 1'b0;
                                end
                            end
                            default: begin
                                r_ovalid <= 1'b0;
                                r_state  <= S_IDLE;
                            end
                        endcase
                    end else if (o_out.ready) begin
                        r_ovalid <= 1'b0;
                    end
                end
                S_FIRE: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        if (w_eligible) begin
                            r_okind <= KIND_FIRED;
                            r_oact  <= w_entry[0].id;
                            r_otype <= w_entry[0].typ;
                            r_oprio <= w_entry[0].prio;
                            r_ohint <= 1'b0;
                            r_fired <= w_fired_inc;
                            if (w_fired_inc == w_lim) begin
                                r_olast <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_olast <= 1'b0;
                            end
                        end else begin
                            r_okind <= KIND_FIRE_DONE;
                            r_oact  <= '0;
                            r_otype <= '0;
                            r_oprio <= '0;
                            r_ohint <= 1'b1;
                            r_olast <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.kind            = r_okind;
    assign o_out.out_action      = r_oact;
    assign o_out.out_type        = r_otype;
    assign o_out.out_priority    = r_oprio;
    assign o_out.reschedule_hint = r_ohint;
    assign o_out.last            = r_olast;

endmodule
`default_nettype wire

// ===== test/deferred_action_priority_queue_top_test.sv =====
`default_nettype none
module deferred_action_priority_queue_top_test;
    import dapq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int LONG_HOLD    = 150;
    localparam int SETTLE_TICKS = MAX_FIRE + 8;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [TYPE_W-1:0] typ;
        logic [PRIO_W-1:0] req_prio;
        logic [PRIO_W-1:0] cur_prio;
    } t_request;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   action;
        logic [TYPE_W-1:0] typ;
        logic [PRIO_W-1:0] prio;
        logic              hint;
        logic              last;
    } t_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [LIMIT_W-1:0]  i_cfg_wdata = '0;

    dapq_in_if  in_bus ();
    dapq_out_if out_bus ();

    deferred_action_priority_queue_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow of the queue
    logic [ID_W-1:0]    order_ids [NUM_ACTIONS];
    int unsigned        depth;
    bit                 marked [NUM_ACTIONS];
    logic [PRIO_W-1:0]  slot_prio [NUM_ACTIONS];
    logic [TYPE_W-1:0]  slot_type [NUM_ACTIONS];
    logic [LIMIT_W-1:0] fire_cap;

    t_request        request_backlog [$];
    t_result         awaited_results [$];
    logic [ID_W-1:0] scheduled_ids [$];

    int  mismatches = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;
    int  hold_requests = 0;

    // drop one slot and close the gap
    function automatic void drop_slot(input int unsigned pos);
        int unsigned i;
        for (i = pos; i + 1 < depth; i++) begin
            order_ids[i] = order_ids[i + 1];
        end
        depth--;
    endfunction

    // apply one accepted request to the shadow queue, queue up its results
    task automatic advance_action_queue(input t_request r);
        t_result         outs [$];
        t_result         one;
        int unsigned     pos;
        int unsigned     i;
        int unsigned     lim;
        int unsigned     fired;
        bit              done;
        logic [ID_W-1:0] head;
        one = '0;
        case (r.op)
            OP_SCHEDULE: begin
                if (marked[r.id]) begin
                    one.kind   = KIND_QUEUED;
                    one.action = r.id;
                    one.typ    = slot_type[r.id];
                    one.prio   = slot_prio[r.id];
                    outs.push_back(one);
                end else begin
                    // behind every entry of equal or lower value
                    pos = 0;
                    while (pos < depth && slot_prio[order_ids[pos]] <= r.req_prio) begin
                        pos++;
                    end
                    for (i = depth; i > pos; i--) begin
                        order_ids[i] = order_ids[i - 1];
                    end
                    order_ids[pos] = r.id;
                    depth++;
                    marked[r.id]    = 1'b1;
                    slot_prio[r.id] = r.req_prio;
                    slot_type[r.id] = r.typ;
                    one.kind   = KIND_SCHEDULED;
                    one.action = r.id;
                    one.typ    = r.typ;
                    one.prio   = r.req_prio;
                    one.hint   = (r.req_prio <= r.cur_prio);
                    outs.push_back(one);
                end
            end
            OP_FIRE: begin
                lim = fire_cap;
                if (lim < 1) lim = 1;
                if (lim > MAX_FIRE) lim = MAX_FIRE;
                if (depth == 0) begin
                    one.kind = KIND_EMPTY;
                    outs.push_back(one);
                end else begin
                    fired = 0;
                    done  = 1'b0;
                    while (!done) begin
                        one = '0;
                        if (depth == 0 || r.cur_prio < slot_prio[order_ids[0]]) begin
                            one.kind = KIND_FIRE_DONE;
                            one.hint = 1'b1;
                            outs.push_back(one);
                            done = 1'b1;
                        end else begin
                            head = order_ids[0];
                            drop_slot(0);
                            marked[head] = 1'b0;
                            one.kind   = KIND_FIRED;
                            one.action = head;
                            one.typ    = slot_type[head];
                            one.prio   = slot_prio[head];
                            outs.push_back(one);
                            fired++;
                            if (fired >= lim) done = 1'b1;
                        end
                    end
                end
            end
            OP_DESCHEDULE: begin
                if (marked[r.id]) begin
                    for (pos = 0; pos < depth; pos++) begin
                        if (order_ids[pos] == r.id) begin
                            drop_slot(pos);
                            break;
                        end
                    end
                    marked[r.id] = 1'b0;
                    one.kind   = KIND_DESCHEDULE;
                    one.action = r.id;
                    one.typ    = slot_type[r.id];
                    one.prio   = slot_prio[r.id];
                    outs.push_back(one);
                end
            end
            default: begin
            end
        endcase
        if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
        foreach (outs[k]) awaited_results.push_back(outs[k]);
    endtask

    // request driver
    t_request on_offer;
    int       send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid            <= 1'b0;
            in_bus.op               <= '0;
            in_bus.action_id        <= '0;
            in_bus.action_type      <= '0;
            in_bus.priority_req     <= '0;
            in_bus.current_priority <= '0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                advance_action_queue(on_offer);
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_bus.valid <= 1'b0;
                end else if (request_backlog.size() != 0) begin
                    on_offer = request_backlog.pop_front();
                    in_bus.valid            <= 1'b1;
                    in_bus.op               <= on_offer.op;
                    in_bus.action_id        <= on_offer.id;
                    in_bus.action_type      <= on_offer.typ;
                    in_bus.priority_req     <= on_offer.req_prio;
                    in_bus.current_priority <= on_offer.cur_prio;
                    if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 9);
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    function automatic bit field_ok(input string name, input int unsigned want,
                                    input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // long hold-off so the block backs up into its input
    int hold_left = 0;
    int holds_done = 0;
    always @(posedge i_clk) begin
        if (holds_done != hold_requests) begin
            holds_done <= holds_done + 1;
            hold_left  <= LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor and receiver stalls
    t_result want;
    bit      all_ok;
    int      recv_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with nothing expected: kind %0d action %0d",
                           out_bus.kind, out_bus.out_action);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    all_ok = 1'b1;
                    all_ok &= field_ok("kind", want.kind, out_bus.kind);
                    all_ok &= field_ok("out_action", want.action, out_bus.out_action);
                    all_ok &= field_ok("out_type", want.typ, out_bus.out_type);
                    all_ok &= field_ok("out_priority", want.prio, out_bus.out_priority);
                    all_ok &= field_ok("reschedule_hint", want.hint, out_bus.reschedule_hint);
                    all_ok &= field_ok("last", want.last, out_bus.last);
                    if (!all_ok) mismatches++;
                end
            end
            if (hold_left > 0) begin
                out_bus.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 9);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("deferred_action_priority_queue_top_test: errors");
            $finish;
        end
    end

    task automatic add_request(input logic [OP_W-1:0] op, input int id, input int typ,
                               input int req, input int cur);
        t_request r;
        r.op       = op;
        r.id       = ID_W'(id);
        r.typ      = TYPE_W'(typ);
        r.req_prio = PRIO_W'(req);
        r.cur_prio = PRIO_W'(cur);
        request_backlog.push_back(r);
    endtask

    // favor a few shared levels so ties are common
    function automatic int pick_priority();
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
                0: return 0;
                1: return 40;
                2: return 128;
                default: return 255;
            endcase
        end
        return $urandom_range(0, 255);
    endfunction

    // empty the queue, fill every action once, then fire them all
    task automatic add_full_drain();
        logic [ID_W-1:0] ids [NUM_ACTIONS];
        logic [ID_W-1:0] tmp;
        int              i;
        int              j;
        add_request(OP_FIRE, $urandom_range(0, 15), $urandom_range(0, 3), $urandom, 255);
        for (i = 0; i < NUM_ACTIONS; i++) ids[i] = ID_W'(i);
        for (i = NUM_ACTIONS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = ids[i];
            ids[i] = ids[j];
            ids[j] = tmp;
        end
        for (i = 0; i < NUM_ACTIONS; i++) begin
            add_request(OP_SCHEDULE, ids[i], $urandom_range(0, 3), pick_priority(), $urandom);
        end
        add_request(OP_FIRE, $urandom_range(0, 15), $urandom_range(0, 3), $urandom, 255);
    endtask

    // mostly schedules and fires, deschedules mostly aimed at earlier schedules
    task automatic add_random_mix(input int count);
        int              k;
        int              pick;
        int              cur;
        logic [ID_W-1:0] id;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            id   = ID_W'($urandom_range(0, NUM_ACTIONS - 1));
            if (pick < 50) begin
                scheduled_ids.push_back(id);
                add_request(OP_SCHEDULE, id, $urandom_range(0, 3), pick_priority(), $urandom);
            end else if (pick < 75) begin
                cur = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(0, 255);
                add_request(OP_FIRE, id, $urandom_range(0, 3), $urandom, cur);
            end else if (pick < 96) begin
                if (scheduled_ids.size() != 0 && $urandom_range(0, 4) != 0) begin
                    id = scheduled_ids[$urandom_range(0, scheduled_ids.size() - 1)];
                end
                add_request(OP_DESCHEDULE, id, $urandom_range(0, 3), $urandom, $urandom);
            end else begin
                add_request(OP_UNUSED, id, $urandom_range(0, 3), $urandom, $urandom);
            end
        end
    endtask

    // block idle: all sent, all answered, fire sequencer settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (request_backlog.size() != 0 || in_bus.valid || awaited_results.size() != 0);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic write_fire_limit(input logic [LIMIT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fire_cap = value;
        @(negedge i_clk);
    endtask

    // stimulus sequence
    initial begin
        depth    = 0;
        fire_cap = LIMIT_RESET;
        foreach (marked[i]) begin
            marked[i]    = 1'b0;
            order_ids[i] = '0;
            slot_prio[i] = '0;
            slot_type[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty fire, ignored requests, ties, requeue, mid removal
        add_request(OP_FIRE,       0, 0,   0,   0);
        add_request(OP_DESCHEDULE, 5, 0,   0,   0);
        add_request(OP_UNUSED,     9, 1,  17,  33);
        add_request(OP_SCHEDULE,   0, 0,   0, 255);
        add_request(OP_SCHEDULE,  15, 3, 255,   0);
        add_request(OP_SCHEDULE,   7, 2, 100, 100);
        add_request(OP_SCHEDULE,   8, 1, 100,  99);
        add_request(OP_SCHEDULE,   7, 0,   3,   3);
        add_request(OP_SCHEDULE,   3, 1, 100,   0);
        add_request(OP_DESCHEDULE, 8, 0,   0,   0);
        add_request(OP_FIRE,       0, 0,   0,  50);
        add_request(OP_FIRE,       0, 0,   0, 255);
        add_request(OP_SCHEDULE,   8, 1, 100, 200);
        add_request(OP_DESCHEDULE, 8, 0,   0,   0);
        add_request(OP_FIRE,       0, 0,   0,   0);
        wait_idle();

        // limit zero acts as one; limit hit leaves no done marker
        write_fire_limit(5'd0);
        add_request(OP_SCHEDULE,   1, 1,  10,   5);
        add_request(OP_SCHEDULE,   2, 2,  20,   5);
        add_request(OP_FIRE,       0, 0,   0, 255);
        add_request(OP_FIRE,       0, 0,   0, 255);
        wait_idle();

        // saturated limit, full queue, long receiver stall
        write_fire_limit(5'd31);
        add_full_drain();
        add_random_mix(36);
        hold_requests <= hold_requests + 1;
        wait_idle();

        write_fire_limit(5'd16);
        add_full_drain();
        add_random_mix(36);
        wait_idle();

        write_fire_limit(5'd1);
        add_random_mix(36);
        wait_idle();

        write_fire_limit(LIMIT_W'($urandom_range(2, 15)));
        add_random_mix(36);
        wait_idle();

        // final stretch without random send or receive gaps
        calm = 1'b1;
        write_fire_limit(5'd5);
        add_random_mix(30);
        wait_idle();

        if (mismatches == 0) begin
            $display("deferred_action_priority_queue_top_test: clean");
        end else begin
            $display("deferred_action_priority_queue_top_test: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
